>>> rtl/cusum_pkg.sv
// Package for the two-sided CUSUM change detector.
// Holds channel widths, register indexes, reset values and the ln2 constant.
// No dependencies.
`default_nettype none
package cusum_pkg;
	localparam int REWARD_W   = 32;
	localparam int INDEX_W    = 32;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int MANT_W     = 31;

	localparam logic [CFG_IDX_W-1:0] REG_TRAINING_COUNT  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_SIZE      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_THRESHOLD = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAUSSIAN_MODE   = 8'd3;

	localparam logic [15:0] TRAINING_COUNT_RST  = 16'd100;
	localparam logic [30:0] SHIFT_SIZE_RST      = 31'd6554;
	localparam logic [30:0] ALARM_THRESHOLD_RST = 31'd327680;
	localparam logic        GAUSSIAN_MODE_RST   = 1'b1;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
endpackage
`default_nettype wire

>>> rtl/cusum_if.sv
// Channel interfaces of the CUSUM detector: reward input, result output and
// configuration write. Depends on cusum_pkg.
`default_nettype none
interface reward_if import cusum_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [REWARD_W-1:0] reward;
	modport source (output valid, output reward, input ready);
	modport sink (input valid, input reward, output ready);
endinterface

interface result_if import cusum_pkg::*;;
	logic               valid;
	logic               ready;
	logic               alarm;
	logic [INDEX_W-1:0] change_index;
	modport source (output valid, output alarm, output change_index, input ready);
	modport sink (input valid, input alarm, input change_index, output ready);
endinterface

interface cfg_if import cusum_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/cusum_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the CUSUM detector top level.
`default_nettype none
module cusum_div #(
	parameter int NW = 64,
	parameter int DW = 48
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient
);
	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   qd_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   dv_q;
	logic [DW:0]     rsh;
	logic            fits;

	assign rsh  = {rem_q, qd_q[NW-1]};
	assign fits = rsh >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qd_q  <= dividend;
			dv_q  <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			qd_q  <= {qd_q[NW-2:0], fits};
			rem_q <= fits ? DW'(rsh - {1'b0, dv_q}) : rsh[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = qd_q;
endmodule
`default_nettype wire

>>> rtl/cusum_mul.sv
// Shared multiplier: an AW-bit by 32-bit product from a registered 32x32 low
// partial product and an upper partial product. Standalone; used by the CUSUM detector top level.
`default_nettype none
module cusum_mul #(
	parameter int AW = 48
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [AW-1:0] a,
	input  wire logic [31:0]   b,
	output logic               done,
	output logic [AW+31:0]     product
);
	logic            st1_q;
	logic            st2_q;
	logic [AW-1:0]   a_q;
	logic [31:0]     b_q;
	logic [63:0]     lo_q;
	logic [AW-1:0]   hi_prod;

	assign hi_prod = a_q[AW-1:32] * b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st1_q <= 1'b0;
			st2_q <= 1'b0;
		end else begin
			st1_q <= start;
			st2_q <= st1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (st1_q) begin
			lo_q <= a_q[31:0] * b_q;
		end
	end

	assign done    = st2_q;
	assign product = {hi_prod, 32'd0} + (AW+32)'(lo_q);
endmodule
`default_nettype wire

>>> rtl/two_sided_cusum_change_detector.sv
// Two-sided CUSUM change detector, top level.
// Depends on cusum_pkg, the channel interfaces, cusum_div and cusum_mul.
//
// Usage: rewards arrive on in_ch (valid/ready), one result per reward leaves
// on out_ch; cfg writes the four registers by index, the user only while the block idles (not enforced).
// A transaction on in_ch is taken only while the sequencer is idle.
// A training sample passes through S_TRAIN and S_OUT; a Bernoulli detection
// sample through S_DET, S_UPD and S_OUT; a Gaussian detection sample adds S_G1
// and two passes through the shared multiplier before S_UPD.
// The last training sample also runs three passes of the restoring divider
// (one bit a cycle, the larger of STAT_WIDTH and 31+FRAC_BITS bits each) and
// up to four logarithms, each a normalising shift of the argument, LOG_ITERATIONS
// squarings on the shared multiplier and a final multiply by ln 2.
// Reset clears the statistics, the sample count and the output channel, and
// loads the registers with their default values.
// When the receiver stalls, the finished result waits in the output register
// and the sequencer holds before its final step until the register is free.
`default_nettype none
module two_sided_cusum_change_detector import cusum_pkg::*; #(
	parameter int FRAC_BITS      = 16,
	parameter int STAT_WIDTH     = 48,
	parameter int COUNT_WIDTH    = 32,
	parameter int LOG_ITERATIONS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	reward_if.sink    in_ch,
	result_if.source  out_ch,
	cfg_if.sink       cfg
);
	localparam int SW   = STAT_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int LI   = LOG_ITERATIONS;
	localparam int CW   = COUNT_WIDTH;
	localparam int DIVW = (SW > 31 + F) ? SW : 31 + F;
	localparam int MAW0 = (SW > LI + 8) ? SW : LI + 8;
	localparam int MAW  = (MAW0 > 33) ? MAW0 : 33;
	localparam int PW   = MAW + 32;
	localparam int PBW  = $clog2(SW);
	localparam int ITW  = $clog2(LI);
	localparam int LNS  = LI + 32 - F;

	localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] ONE  = {{(SW-1-F){1'b0}}, 1'b1, {F{1'b0}}};
	localparam logic signed [SW-1:0] HALF_ONE = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_TRAIN  = 5'd1;
	localparam logic [4:0] S_MDIV   = 5'd2;
	localparam logic [4:0] S_QDIV1  = 5'd3;
	localparam logic [4:0] S_QDIV2  = 5'd4;
	localparam logic [4:0] S_DWAIT  = 5'd5;
	localparam logic [4:0] S_LOGARG = 5'd6;
	localparam logic [4:0] S_LNORM  = 5'd7;
	localparam logic [4:0] S_LSQ    = 5'd8;
	localparam logic [4:0] S_LSQD   = 5'd9;
	localparam logic [4:0] S_LLN    = 5'd10;
	localparam logic [4:0] S_LLND   = 5'd11;
	localparam logic [4:0] S_DET    = 5'd12;
	localparam logic [4:0] S_G1     = 5'd13;
	localparam logic [4:0] S_GMP    = 5'd14;
	localparam logic [4:0] S_GMPD   = 5'd15;
	localparam logic [4:0] S_GMM    = 5'd16;
	localparam logic [4:0] S_GMMD   = 5'd17;
	localparam logic [4:0] S_UPD    = 5'd18;
	localparam logic [4:0] S_OUT    = 5'd19;

	localparam logic [1:0] JOB_MEAN = 2'd0;
	localparam logic [1:0] JOB_Q1   = 2'd1;
	localparam logic [1:0] JOB_Q2   = 2'd2;

	function automatic logic signed [SW-1:0] sat1(input logic [SW:0] v);
		if (v[SW] != v[SW-1]) begin
			return v[SW] ? SMIN : SMAX;
		end
		return v[SW-1:0];
	endfunction

	function automatic logic signed [SW-1:0] add_sat(input logic [SW-1:0] a,
			input logic [SW-1:0] b);
		return sat1({a[SW-1], a} + {b[SW-1], b});
	endfunction

	function automatic logic signed [SW-1:0] sub_sat(input logic [SW-1:0] a,
			input logic [SW-1:0] b);
		return sat1({a[SW-1], a} - {b[SW-1], b});
	endfunction

	function automatic logic [SW-1:0] mag(input logic [SW-1:0] a);
		return a[SW-1] ? SW'(0) - a : a;
	endfunction

	function automatic logic signed [SW-1:0] msat(input logic [PW-1:0] u,
			input logic neg);
		if (u[PW-1:SW-1] != '0) begin
			return neg ? SMIN : SMAX;
		end
		return neg ? SW'(0) - {1'b0, u[SW-2:0]} : {1'b0, u[SW-2:0]};
	endfunction

	function automatic logic signed [SW-1:0] dsat(input logic [DIVW-1:0] q,
			input logic neg);
		if (q[DIVW-1:SW-1] != '0) begin
			return neg ? SMIN : SMAX;
		end
		return neg ? SW'(0) - {1'b0, q[SW-2:0]} : {1'b0, q[SW-2:0]};
	endfunction

	logic [15:0] tc_q;
	logic [30:0] eps_q;
	logic [30:0] thr_q;
	logic        gm_q;

	logic [4:0]  state_q;
	logic [CW-1:0] cnt_q;
	logic signed [SW-1:0] mean_q, ps_q, ns_q, pc_q, pcm_q, nc_q, ncm_q;
	logic [CW-1:0] pidx_q, nidx_q;
	logic signed [SW-1:0] r_q, dp_q, dm_q, sp_q, sm_q, q1_q, q2_q;
	logic signed [SW-1:0] inc_q [4];
	logic        dneg_q, dzero_q, lneg_q, det_q;
	logic [1:0]  job_q, k_q;
	logic [SW-1:0] v_q;
	logic [PBW-1:0] p_q;
	logic [MANT_W-1:0] m_q;
	logic [LI-1:0] frac_q;
	logic [ITW-1:0] it_q;

	logic        out_valid_q, out_alarm_q;
	logic [INDEX_W-1:0] out_idx_q;

	logic            div_start, div_done;
	logic [DIVW-1:0] div_a, div_q;
	logic [SW-1:0]   div_b;
	logic            mul_start, mul_done;
	logic [MAW-1:0]  mul_a;
	logic [31:0]     mul_b;
	logic [PW-1:0]   mul_p;

	logic signed [SW-1:0] arg_k, den1, den2, half_s, thr_s;
	logic signed [SW-1:0] ps_sum, ns_sum, pc_new, nc_new;
	logic [DIVW-1:0] num;
	logic [7:0]      e8;
	logic signed [LI+7:0] l2;
	logic [31:0]     mm;
	logic            in_acc, out_free, p_hit, n_hit;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.alarm        = out_alarm_q;
	assign out_ch.change_index = out_idx_q;

	assign num    = DIVW'({eps_q, {F{1'b0}}});
	assign den1   = mean_q;
	assign den2   = sub_sat(ONE, mean_q);
	assign half_s = SW'(eps_q >> 1);
	assign thr_s  = SW'(thr_q);
	assign e8     = 8'(p_q) - 8'(F);
	assign l2     = {e8, frac_q};
	assign mm     = mul_p[61:30];
	assign ps_sum = add_sat(ps_q, sp_q);
	assign ns_sum = add_sat(ns_q, sm_q);
	assign pc_new = add_sat(pc_q, sp_q);
	assign nc_new = add_sat(nc_q, sm_q);
	assign p_hit  = ps_q > thr_s;
	assign n_hit  = ns_q > thr_s;

	always_comb begin
		case (k_q)
			2'd0: arg_k = add_sat(ONE, q1_q);
			2'd1: arg_k = sub_sat(ONE, q1_q);
			2'd2: arg_k = sub_sat(ONE, q2_q);
			default: arg_k = add_sat(ONE, q2_q);
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_a     = num;
		div_b     = mag(den1);
		mul_start = 1'b0;
		mul_a     = MAW'(m_q);
		mul_b     = 32'(m_q);
		case (state_q)
			S_MDIV: begin
				div_start = 1'b1;
				div_a     = DIVW'(mag(mean_q));
				div_b     = SW'(tc_q);
			end
			S_QDIV1: begin
				div_start = 1'b1;
			end
			S_QDIV2: begin
				div_start = 1'b1;
				div_b     = mag(den2);
			end
			S_LSQ: begin
				mul_start = 1'b1;
			end
			S_LLN: begin
				mul_start = 1'b1;
				mul_a     = MAW'(l2[LI+7] ? (LI+8)'(0) - l2 : l2);
				mul_b     = LN2_Q32;
			end
			S_GMP: begin
				mul_start = 1'b1;
				mul_a     = MAW'(mag(dp_q));
				mul_b     = 32'(eps_q);
			end
			S_GMM: begin
				mul_start = 1'b1;
				mul_a     = MAW'(mag(dm_q));
				mul_b     = 32'(eps_q);
			end
			default: begin
			end
		endcase
	end

	cusum_div #(.NW(DIVW), .DW(SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	cusum_mul #(.AW(MAW)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q  <= TRAINING_COUNT_RST;
			eps_q <= SHIFT_SIZE_RST;
			thr_q <= ALARM_THRESHOLD_RST;
			gm_q  <= GAUSSIAN_MODE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TRAINING_COUNT:  tc_q  <= cfg.data[15:0];
				REG_SHIFT_SIZE:      eps_q <= cfg.data[30:0];
				REG_ALARM_THRESHOLD: thr_q <= cfg.data[30:0];
				REG_GAUSSIAN_MODE:   gm_q  <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			mean_q      <= '0;
			ps_q        <= '0;
			ns_q        <= '0;
			pc_q        <= '0;
			pcm_q       <= '0;
			nc_q        <= '0;
			ncm_q       <= '0;
			pidx_q      <= '0;
			nidx_q      <= '0;
			out_valid_q <= 1'b0;
			job_q       <= JOB_MEAN;
			k_q         <= '0;
			det_q       <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + 1'b1;
						end
						det_q   <= !(cnt_q < CW'(tc_q));
						state_q <= (cnt_q < CW'(tc_q)) ? S_TRAIN : S_DET;
					end
				end
				S_TRAIN: begin
					mean_q  <= add_sat(mean_q, r_q);
					state_q <= (cnt_q == CW'(tc_q)) ? S_MDIV : S_OUT;
				end
				S_MDIV: begin
					job_q   <= JOB_MEAN;
					state_q <= S_DWAIT;
				end
				S_QDIV1: begin
					job_q   <= JOB_Q1;
					state_q <= S_DWAIT;
				end
				S_QDIV2: begin
					job_q   <= JOB_Q2;
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						case (job_q)
							JOB_MEAN: begin
								mean_q  <= dsat(div_q, mean_q[SW-1]);
								state_q <= S_QDIV1;
							end
							JOB_Q1: begin
								state_q <= S_QDIV2;
							end
							default: begin
								k_q     <= '0;
								state_q <= S_LOGARG;
							end
						endcase
					end
				end
				S_LOGARG: begin
					if (arg_k <= 0) begin
						k_q     <= k_q + 1'b1;
						state_q <= (k_q == 2'd3) ? S_OUT : S_LOGARG;
					end else begin
						state_q <= S_LNORM;
					end
				end
				S_LNORM: begin
					if (v_q[SW-1]) begin
						state_q <= S_LSQ;
					end
				end
				S_LSQ: begin
					state_q <= S_LSQD;
				end
				S_LSQD: begin
					if (mul_done) begin
						state_q <= (it_q == ITW'(LI - 1)) ? S_LLN : S_LSQ;
					end
				end
				S_LLN: begin
					state_q <= S_LLND;
				end
				S_LLND: begin
					if (mul_done) begin
						k_q     <= k_q + 1'b1;
						state_q <= (k_q == 2'd3) ? S_OUT : S_LOGARG;
					end
				end
				S_DET: begin
					state_q <= gm_q ? S_G1 : S_UPD;
				end
				S_G1: begin
					state_q <= S_GMP;
				end
				S_GMP: begin
					state_q <= S_GMPD;
				end
				S_GMPD: begin
					if (mul_done) begin
						state_q <= S_GMM;
					end
				end
				S_GMM: begin
					state_q <= S_GMMD;
				end
				S_GMMD: begin
					if (mul_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					ps_q <= ps_sum[SW-1] ? '0 : ps_sum;
					ns_q <= ns_sum[SW-1] ? '0 : ns_sum;
					pc_q <= pc_new;
					nc_q <= nc_new;
					if (pc_new <= pcm_q) begin
						pcm_q  <= pc_new;
						pidx_q <= cnt_q;
					end
					if (nc_new <= ncm_q) begin
						ncm_q  <= nc_new;
						nidx_q <= cnt_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				r_q <= SW'(in_ch.reward);
			end
			S_DWAIT: begin
				if (div_done && job_q == JOB_Q1) begin
					q1_q <= dzero_q ? ((eps_q == '0) ? '0 : SMAX) : dsat(div_q, dneg_q);
				end
				if (div_done && job_q == JOB_Q2) begin
					q2_q <= dzero_q ? ((eps_q == '0) ? '0 : SMAX) : dsat(div_q, dneg_q);
				end
			end
			S_QDIV1: begin
				dneg_q  <= den1[SW-1];
				dzero_q <= (den1 == '0);
			end
			S_QDIV2: begin
				dneg_q  <= den2[SW-1];
				dzero_q <= (den2 == '0);
			end
			S_LOGARG: begin
				if (arg_k <= 0) begin
					inc_q[k_q] <= SMIN;
				end
				v_q <= arg_k;
				p_q <= PBW'(SW - 1);
			end
			S_LNORM: begin
				if (v_q[SW-1]) begin
					m_q    <= v_q[SW-1 -: MANT_W];
					frac_q <= '0;
					it_q   <= '0;
				end else begin
					v_q <= {v_q[SW-2:0], 1'b0};
					p_q <= p_q - 1'b1;
				end
			end
			S_LSQD: begin
				if (mul_done) begin
					frac_q <= {frac_q[LI-2:0], mm[31]};
					m_q    <= mm[31] ? mm[31:1] : mm[30:0];
					it_q   <= it_q + 1'b1;
				end
			end
			S_LLN: begin
				lneg_q <= l2[LI+7];
			end
			S_LLND: begin
				if (mul_done) begin
					inc_q[k_q] <= msat(mul_p >> LNS, lneg_q);
				end
			end
			S_DET: begin
				dp_q <= sub_sat(r_q, mean_q);
				dm_q <= sub_sat(mean_q, r_q);
				if (r_q > HALF_ONE) begin
					sp_q <= inc_q[0];
					sm_q <= inc_q[1];
				end else begin
					sp_q <= inc_q[2];
					sm_q <= inc_q[3];
				end
			end
			S_G1: begin
				dp_q <= sub_sat(dp_q, half_s);
				dm_q <= sub_sat(dm_q, half_s);
			end
			S_GMPD: begin
				if (mul_done) begin
					sp_q <= msat(mul_p >> F, dp_q[SW-1]);
				end
			end
			S_GMMD: begin
				if (mul_done) begin
					sm_q <= msat(mul_p >> F, dm_q[SW-1]);
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_alarm_q <= det_q && (p_hit || n_hit);
					out_idx_q   <= !det_q ? '0 :
						p_hit ? INDEX_W'(pidx_q) : n_hit ? INDEX_W'(nidx_q) : '0;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire
